/* rtl/xet_pkg.sv */
// ----------------------------------------------------------------------------
// xet_pkg
// Types, parse modes and delimiter bytes shared by the XML event tokenizer.
// ----------------------------------------------------------------------------
package xet_pkg;

	// one document byte on the input channel
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
		logic       capture_on;
	} in_t;

	// one token byte or one parser event on the output channel
	typedef struct packed {
		logic       text_valid;
		logic [7:0] text_byte;
		logic       event_valid;
		logic [2:0] event_code;
		logic       last;
	} out_t;

	// parse modes, equal to the event codes reported
	localparam logic [2:0] M_BEGIN         = 3'd0;
	localparam logic [2:0] M_TAG_START     = 3'd1;
	localparam logic [2:0] M_NAME_END      = 3'd2;
	localparam logic [2:0] M_ATTR_START    = 3'd3;
	localparam logic [2:0] M_ATTR_NAME_END = 3'd4;
	localparam logic [2:0] M_ATTR_END      = 3'd5;
	localparam logic [2:0] M_TAG_END       = 3'd6;
	localparam logic [2:0] M_FILE_END      = 3'd7;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LBRACK = 8'h5B;

	// bytes of "CDATA[" still to eat once "<![" is seen
	localparam logic [2:0] CdataOpenRest = 3'd6;

	localparam int MaxRes = 4;

endpackage

/* rtl/xet_if.sv */
// ----------------------------------------------------------------------------
// xet_doc_if / xet_tok_if
// Valid/ready channels for document bytes and for tokenizer results.
// ----------------------------------------------------------------------------
interface xet_doc_if import xet_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface xet_tok_if import xet_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/xml_event_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// xml_event_tokenizer_core
// Streaming XML tokenizer: one document byte in, up to three token bytes or
// parser events out, comments dropped and CDATA passed through as text.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           transfer
//  doc      in   in_byte, end_of_file, capture_on                  valid & ready
//  tok      out  text_valid, text_byte, event_valid, event_code,   valid & ready
//               last
//
// A byte goes through an input register, is parsed and its results are
// loaded into a four-entry result buffer drained one per cycle while tok is
// ready. Bytes giving zero or one result then flow at one byte per cycle; a
// byte giving more holds the next one back until its last result is taken.
// A stall on tok backs up into doc once the input register is full.
// arst_n clears the parse state and empties both registers.
module xml_event_tokenizer_core import xet_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	xet_doc_if.sink   doc,
	xet_tok_if.source tok
);

	typedef struct packed {
		logic       v0;
		out_t       r0;
		logic       v1;
		out_t       r1;
		logic [2:0] mode;
		logic       skip;
	} step_t;

	function automatic out_t ev_res(logic [2:0] code);
		out_t r;
		r = '0;
		r.event_valid = 1'b1;
		r.event_code = code;
		return r;
	endfunction

	function automatic out_t tx_res(logic [7:0] c);
		out_t r;
		r = '0;
		r.text_valid = 1'b1;
		r.text_byte = c;
		return r;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
			c == 8'h0C || c == 8'h0D;
	endfunction

	// one byte in any mode but tag end; an attribute lead byte is parsed again
	// as the first byte of the name, hence the second result
	function automatic step_t mode_step(logic [2:0] m, logic [7:0] c, logic cap);
		step_t s;
		s = '0;
		s.mode = m;
		unique case (m)
			M_BEGIN: begin
				if (c == CH_LT) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_TAG_START); s.mode = M_TAG_START;
				end else begin
					s.v0 = cap; s.r0 = tx_res(c);
				end
			end
			M_TAG_START: begin
				priority if (c == CH_GT) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_TAG_END); s.mode = M_TAG_END;
				end else if (is_ws(c)) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_NAME_END); s.mode = M_NAME_END;
				end else begin
					s.v0 = cap; s.r0 = tx_res(c);
				end
			end
			M_NAME_END, M_ATTR_END: begin
				priority if (c == CH_SLASH || (m == M_ATTR_END && c == CH_QMARK)) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_TAG_END); s.mode = M_TAG_END;
					s.skip = 1'b1;
				end else if (c == CH_GT) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_TAG_END); s.mode = M_TAG_END;
				end else if (is_ws(c)) begin
					s.v0 = cap; s.r0 = tx_res(c);
				end else begin
					s.v0 = 1'b1; s.r0 = ev_res(M_ATTR_START);
					if (c == CH_EQ) begin
						s.v1 = 1'b1; s.r1 = ev_res(M_ATTR_NAME_END);
						s.mode = M_ATTR_NAME_END; s.skip = 1'b1;
					end else begin
						s.v1 = cap; s.r1 = tx_res(c); s.mode = M_ATTR_START;
					end
				end
			end
			M_ATTR_START: begin
				if (c == CH_EQ) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_ATTR_NAME_END);
					s.mode = M_ATTR_NAME_END; s.skip = 1'b1;
				end else begin
					s.v0 = cap; s.r0 = tx_res(c);
				end
			end
			M_ATTR_NAME_END: begin
				if (c == CH_QUOTE) begin
					s.v0 = 1'b1; s.r0 = ev_res(M_ATTR_END); s.mode = M_ATTR_END;
				end else begin
					s.v0 = cap; s.r0 = tx_res(c);
				end
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// input register
	logic       valid_s1;
	in_t        data_s1;

	// parse state
	logic [2:0] mode_q, mode_d;
	logic       cdata_q, cdata_d;
	logic       comment_q, comment_d;
	logic [1:0] la_cnt_q, la_cnt_d;
	logic [2:0] skip_q, skip_d;
	logic [1:0] term_q, term_d;

	// result buffer
	out_t       res_q [MaxRes];
	logic [2:0] rem_q;
	logic [1:0] rd_q;

	step_t      ms, ms_tag;
	logic [3:0] cv;
	out_t       cand [MaxRes];
	out_t       list [MaxRes];
	logic [2:0] n_res;
	logic [1:0] last_idx;
	logic       buf_free;
	logic       commit;
	logic [7:0] c;
	logic       cap;

	assign c = data_s1.in_byte;
	assign cap = data_s1.capture_on;

	assign buf_free = (rem_q == 3'd0) || (rem_q == 3'd1 && tok.ready);
	assign commit = valid_s1 && buf_free;
	assign doc.ready = !valid_s1 || commit;
	assign tok.valid = rem_q != 3'd0;
	assign tok.data = res_q[rd_q];

	always_comb begin
		ms = mode_step(mode_q, c, cap);
		ms_tag = mode_step(M_TAG_START, c, cap);
		cv = '0;
		for (int i = 0; i < MaxRes; i++) begin
			cand[i] = '0;
		end
		mode_d = mode_q;
		cdata_d = cdata_q;
		comment_d = comment_q;
		la_cnt_d = la_cnt_q;
		skip_d = skip_q;
		term_d = term_q;
		priority if (mode_q == M_FILE_END) begin
		end else if (data_s1.end_of_file) begin
			la_cnt_d = 2'd0;
			term_d = 2'd0;
			skip_d = 3'd0;
			cv[0] = 1'b1; cand[0] = ev_res(M_FILE_END);
			mode_d = M_FILE_END;
		end else if (skip_q != 3'd0) begin
			skip_d = skip_q - 3'd1;
		end else if (mode_q != M_TAG_END) begin
			cv[0] = ms.v0; cand[0] = ms.r0;
			cv[1] = ms.v1; cand[1] = ms.r1;
			mode_d = ms.mode;
			if (ms.skip) begin
				skip_d = 3'd1;
			end
		end else if (cdata_q) begin
			// held ']' bytes come out as text once the match breaks
			priority if (term_q == 2'd0) begin
				if (c == CH_RBRACK) begin
					term_d = 2'd1;
				end else begin
					cv[0] = cap; cand[0] = tx_res(c);
				end
			end else if (term_q == 2'd1) begin
				if (c == CH_RBRACK) begin
					term_d = 2'd2;
				end else begin
					term_d = 2'd0;
					cv[0] = cap; cand[0] = tx_res(CH_RBRACK);
					cv[1] = cap; cand[1] = tx_res(c);
				end
			end else begin
				priority if (c == CH_GT) begin
					term_d = 2'd0;
					cdata_d = 1'b0;
				end else if (c == CH_RBRACK) begin
					cv[0] = cap; cand[0] = tx_res(CH_RBRACK);
				end else begin
					term_d = 2'd0;
					cv[0] = cap; cand[0] = tx_res(CH_RBRACK);
					cv[1] = cap; cand[1] = tx_res(CH_RBRACK);
					cv[2] = cap; cand[2] = tx_res(c);
				end
			end
		end else if (comment_q) begin
			priority if (term_q == 2'd0) begin
				if (c == CH_DASH) begin
					term_d = 2'd1;
				end
			end else if (term_q == 2'd1) begin
				term_d = (c == CH_DASH) ? 2'd2 : 2'd0;
			end else begin
				priority if (c == CH_GT) begin
					term_d = 2'd0;
					comment_d = 1'b0;
				end else if (c != CH_DASH) begin
					term_d = 2'd0;
				end else begin
				end
			end
		end else if (la_cnt_q == 2'd1) begin
			if (c == CH_BANG) begin
				la_cnt_d = 2'd2;
			end else begin
				la_cnt_d = 2'd0;
				cv[0] = 1'b1; cand[0] = ev_res(M_TAG_START);
				cv[1] = ms_tag.v0; cand[1] = ms_tag.r0;
				mode_d = ms_tag.mode;
			end
		end else if (la_cnt_q[1]) begin
			// the second held byte can only be '!', so it is not stored
			la_cnt_d = 2'd0;
			priority if (c == CH_LBRACK) begin
				cdata_d = 1'b1;
				term_d = 2'd0;
				skip_d = CdataOpenRest;
			end else if (c == CH_DASH) begin
				comment_d = 1'b1;
				term_d = 2'd0;
				skip_d = 3'd1;
			end else begin
				cv[0] = 1'b1; cand[0] = ev_res(M_TAG_START);
				cv[1] = cap; cand[1] = tx_res(CH_BANG);
				cv[2] = ms_tag.v0; cand[2] = ms_tag.r0;
				mode_d = ms_tag.mode;
			end
		end else if (c == CH_LT) begin
			la_cnt_d = 2'd1;
		end else begin
			cv[0] = cap; cand[0] = tx_res(c);
		end
	end

	// pack the live results to the front and mark the final one
	always_comb begin
		n_res = 3'd0;
		for (int i = 0; i < MaxRes; i++) begin
			list[i] = '0;
		end
		for (int i = 0; i < MaxRes; i++) begin
			if (cv[i]) begin
				list[n_res[1:0]] = cand[i];
				n_res = n_res + 3'd1;
			end
		end
		last_idx = 2'(n_res - 3'd1);
		if (n_res != 3'd0) begin
			list[last_idx].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (doc.valid && doc.ready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (doc.valid && doc.ready) begin
			data_s1 <= doc.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BEGIN;
			cdata_q <= 1'b0;
			comment_q <= 1'b0;
			la_cnt_q <= 2'd0;
			skip_q <= 3'd0;
			term_q <= 2'd0;
		end else if (commit) begin
			mode_q <= mode_d;
			cdata_q <= cdata_d;
			comment_q <= comment_d;
			la_cnt_q <= la_cnt_d;
			skip_q <= skip_d;
			term_q <= term_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q <= 2'd0;
		end else if (commit) begin
			rem_q <= n_res;
			rd_q <= 2'd0;
		end else if (tok.valid && tok.ready) begin
			rem_q <= rem_q - 3'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < MaxRes; i++) begin
				res_q[i] <= list[i];
			end
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(MaxRes))
		else $error("result buffer count beyond its depth");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && rem_q == 3'd1 |-> tok.data.last)
		else $error("final result of a byte not marked last");

	a_last_early: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && rem_q > 3'd1 |-> !tok.data.last)
		else $error("last marked before the final result");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid |-> (tok.data.text_valid ^ tok.data.event_valid))
		else $error("result is neither or both of text and event");

	a_file_end_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_FILE_END |=> mode_q == M_FILE_END)
		else $error("parser left the file end mode");

endmodule

/* verif/tb_xml_event_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// tb_xml_event_tokenizer_core
// Self-checking bench for the XML event tokenizer. Document bytes go in on
// doc, token bytes and parser events come back on tok. A behavioural
// tokenizer predicts the tokens of every accepted byte, and each tok
// transfer is checked against the oldest prediction. Directed documents
// cover each event and the delimiter corner cases; random well-formed
// fragments mixed with noise follow, with random gaps on both sides, after
// one long stall on tok. End of file comes last, since it ends the parse.
// ----------------------------------------------------------------------------
module tb_xml_event_tokenizer_core;
	import xet_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 200;
	localparam int DrainCycles = 60;
	localparam int unsigned CycleLimit = 200000;
	localparam int StallCycles = 80;
	localparam logic [7:0] SpaceBytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xet_doc_if doc_if ();
	xet_tok_if tok_if ();

	xml_event_tokenizer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.doc    (doc_if),
		.tok    (tok_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int unsigned cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	bit send_eager = 1'b0;
	bit recv_eager = 1'b0;
	bit capture_all = 1'b1;
	int hold_off_cycles = 0;

	// tokenizer state
	logic [2:0] mode_q = M_BEGIN;
	bit in_cdata_q = 1'b0;
	bit in_comment_q = 1'b0;
	logic [7:0] held_bang = 8'h00;
	logic [1:0] held_cnt = 2'd0;
	logic [2:0] skip_left = 3'd0;
	logic [1:0] term_seen = 2'd0;
	bit capture_now = 1'b0;

	out_t byte_tokens[$];
	out_t pending_tokens[$];
	out_t tok_want;

	function automatic bit is_space(logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	endfunction

	function automatic void add_text(logic [7:0] c);
		out_t t;
		t = '0;
		t.text_valid = 1'b1;
		t.text_byte = c;
		if (capture_now && byte_tokens.size() < MaxRes)
			byte_tokens.push_back(t);
	endfunction

	function automatic void add_event(logic [2:0] m);
		out_t t;
		t = '0;
		t.event_valid = 1'b1;
		t.event_code = m;
		mode_q = m;
		if (byte_tokens.size() < MaxRes)
			byte_tokens.push_back(t);
	endfunction

	function automatic void attr_name_byte(logic [7:0] c);
		if (c == CH_EQ) begin
			add_event(M_ATTR_NAME_END);
			skip_left = 3'd1;
		end else
			add_text(c);
	endfunction

	function automatic void parse_in_tag(logic [7:0] c);
		case (mode_q)
			M_BEGIN: if (c == CH_LT) add_event(M_TAG_START); else add_text(c);
			M_TAG_START: begin
				if (c == CH_GT) add_event(M_TAG_END);
				else if (is_space(c)) add_event(M_NAME_END);
				else add_text(c);
			end
			M_NAME_END, M_ATTR_END: begin
				if (c == CH_SLASH || (mode_q == M_ATTR_END && c == CH_QMARK)) begin
					add_event(M_TAG_END);
					skip_left = 3'd1;
				end else if (c == CH_GT) begin
					add_event(M_TAG_END);
				end else if (is_space(c)) begin
					add_text(c);
				end else begin
					// lead byte doubles as first byte of the attribute name
					add_event(M_ATTR_START);
					attr_name_byte(c);
				end
			end
			M_ATTR_START: attr_name_byte(c);
			M_ATTR_NAME_END: if (c == CH_QUOTE) add_event(M_ATTR_END); else add_text(c);
			default: ;
		endcase
	endfunction

	function automatic void parse_after_tag(logic [7:0] c);
		if (in_cdata_q) begin
			case (term_seen)
				2'd0: if (c == CH_RBRACK) term_seen = 2'd1; else add_text(c);
				2'd1: begin
					if (c == CH_RBRACK) begin
						term_seen = 2'd2;
					end else begin
						term_seen = 2'd0;
						add_text(CH_RBRACK);
						add_text(c);
					end
				end
				default: begin
					if (c == CH_GT) begin
						term_seen = 2'd0;
						in_cdata_q = 1'b0;
					end else if (c == CH_RBRACK) begin
						add_text(CH_RBRACK);
					end else begin
						term_seen = 2'd0;
						add_text(CH_RBRACK);
						add_text(CH_RBRACK);
						add_text(c);
					end
				end
			endcase
		end else if (in_comment_q) begin
			case (term_seen)
				2'd0: if (c == CH_DASH) term_seen = 2'd1;
				2'd1: term_seen = (c == CH_DASH) ? 2'd2 : 2'd0;
				default: begin
					if (c == CH_GT) begin
						term_seen = 2'd0;
						in_comment_q = 1'b0;
					end else if (c != CH_DASH) begin
						term_seen = 2'd0;
					end
				end
			endcase
		end else if (held_cnt == 2'd1) begin
			if (c == CH_BANG) begin
				held_bang = c;
				held_cnt = 2'd2;
			end else begin
				held_cnt = 2'd0;
				add_event(M_TAG_START);
				parse_in_tag(c);
			end
		end else if (held_cnt >= 2'd2) begin
			held_cnt = 2'd0;
			if (c == CH_LBRACK) begin
				in_cdata_q = 1'b1;
				term_seen = 2'd0;
				skip_left = CdataOpenRest;
			end else if (c == CH_DASH) begin
				in_comment_q = 1'b1;
				term_seen = 2'd0;
				skip_left = 3'd1;
			end else begin
				// failed bang: the held '!' and this byte are parsed as in a tag start
				add_event(M_TAG_START);
				parse_in_tag(held_bang);
				parse_in_tag(c);
			end
		end else if (c == CH_LT) begin
			held_cnt = 2'd1;
		end else begin
			add_text(c);
		end
	endfunction

	function automatic void tokenize_byte(in_t it);
		out_t t;
		byte_tokens.delete();
		capture_now = it.capture_on;
		if (mode_q == M_FILE_END) begin
			// parse is over, nothing more comes out
		end else if (it.end_of_file) begin
			held_cnt = 2'd0;
			term_seen = 2'd0;
			skip_left = 3'd0;
			add_event(M_FILE_END);
		end else if (skip_left != 3'd0) begin
			skip_left = skip_left - 3'd1;
		end else if (mode_q == M_TAG_END) begin
			parse_after_tag(it.in_byte);
		end else begin
			parse_in_tag(it.in_byte);
		end
		foreach (byte_tokens[i]) begin
			t = byte_tokens[i];
			t.last = (i == byte_tokens.size() - 1);
			pending_tokens.push_back(t);
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("error at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic compare_token(out_t got, out_t want);
		if (got.text_valid !== want.text_valid)
			report_mismatch($sformatf("text_valid %0b, want %0b", got.text_valid, want.text_valid));
		if (got.text_byte !== want.text_byte)
			report_mismatch($sformatf("text_byte %02h, want %02h", got.text_byte, want.text_byte));
		if (got.event_valid !== want.event_valid)
			report_mismatch($sformatf("event_valid %0b, want %0b", got.event_valid,
				want.event_valid));
		if (got.event_code !== want.event_code)
			report_mismatch($sformatf("event_code %0d, want %0d", got.event_code, want.event_code));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
	endtask

	// one document byte: random gap, then hold valid until the transfer
	task automatic send_item(logic [7:0] b, bit eof, bit cap);
		int gap;
		in_t it;
		gap = send_eager ? 0 : $urandom_range(0, 9);
		it.in_byte = b;
		it.end_of_file = eof;
		it.capture_on = cap;
		if (gap > 0) begin
			@(negedge clk);
			doc_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		doc_if.valid <= 1'b1;
		doc_if.data <= it;
		do @(posedge clk); while (!doc_if.ready);
		tokenize_byte(it);
		items_sent++;
	endtask

	function automatic bit pick_capture();
		return capture_all || ($urandom_range(0, 3) != 0);
	endfunction

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0, pick_capture());
	endtask

	function automatic logic [7:0] rand_space();
		return SpaceBytes[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] rand_name_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(8'h41, 8'h5A));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// any byte but the ones that open a tag or close a value
	function automatic logic [7:0] rand_text_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_LT || b == CH_QUOTE);
		return b;
	endfunction

	task automatic send_name();
		int n;
		n = $urandom_range(0, 1) ? 1 : $urandom_range(2, 5);
		repeat (n) send_item(rand_name_byte(), 1'b0, pick_capture());
	endtask

	task automatic send_attr();
		int n;
		n = $urandom_range(1, 2);
		repeat (n) send_item(rand_space(), 1'b0, pick_capture());
		send_name();
		send_item(CH_EQ, 1'b0, pick_capture());
		send_item(CH_QUOTE, 1'b0, pick_capture());
		n = $urandom_range(0, 4);
		repeat (n) send_item(rand_text_byte(), 1'b0, pick_capture());
		send_item(CH_QUOTE, 1'b0, pick_capture());
	endtask

	task automatic test_tags_and_attributes();
		capture_all = 1'b1;
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_text("<a");
		send_item(8'h09, 1'b0, 1'b1);
		send_item(8'h20, 1'b0, 1'b1);
		// '>' after '=' is eaten, so is '<' after '?'
		send_text("k=>v\"?<");
	endtask

	task automatic test_lookahead_and_bang();
		send_text("<b");
		send_item(8'h0A, 1'b0, 1'b1);
		send_text("/q<!><!");
		send_item(8'h0B, 1'b0, 1'b1);
		send_item(8'h0C, 1'b0, 1'b1);
		send_item(8'h0D, 1'b0, 1'b1);
		send_item(CH_GT, 1'b0, 1'b1);
	endtask

	task automatic test_comment_and_cdata();
		send_text("<!--c--->");
		send_text("<![CDATA[");
		// broken terminators after one and after two ']'
		send_text("]e]]]f]]>");
	endtask

	task automatic test_output_stall();
		send_eager = 1'b1;
		hold_off_cycles = StallCycles;
		send_text("<ab c=\"d\">xy</ab>");
		send_eager = 1'b0;
	endtask

	task automatic test_random_documents();
		int n;
		int first;
		first = items_sent;
		capture_all = 1'b0;
		while (items_sent - first < RandomItems) begin
			send_eager = ($urandom_range(0, 7) == 0);
			recv_eager = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 6);
					repeat (n) send_item(rand_text_byte(), 1'b0, pick_capture());
				end
				2, 3: begin
					send_item(CH_LT, 1'b0, pick_capture());
					send_name();
					n = $urandom_range(0, 2);
					repeat (n) send_attr();
					if ($urandom_range(0, 2) == 0) begin
						if ($urandom_range(0, 1)) send_item(rand_space(), 1'b0, pick_capture());
						send_item(CH_SLASH, 1'b0, pick_capture());
					end
					send_item(CH_GT, 1'b0, pick_capture());
				end
				4: begin
					send_item(CH_LT, 1'b0, pick_capture());
					send_item(CH_SLASH, 1'b0, pick_capture());
					send_name();
					if ($urandom_range(0, 2) == 0) send_item(rand_space(), 1'b0, pick_capture());
					send_item(CH_GT, 1'b0, pick_capture());
				end
				5: begin
					send_item(CH_LT, 1'b0, pick_capture());
					send_item(CH_QMARK, 1'b0, pick_capture());
					send_name();
					n = $urandom_range(0, 2);
					repeat (n) send_attr();
					send_item(CH_QMARK, 1'b0, pick_capture());
					send_item(CH_GT, 1'b0, pick_capture());
				end
				6: begin
					send_text("<!--");
					n = $urandom_range(0, 6);
					repeat (n) begin
						case ($urandom_range(0, 3))
							0: send_item(CH_DASH, 1'b0, pick_capture());
							1: send_item(CH_GT, 1'b0, pick_capture());
							default: send_item(rand_text_byte(), 1'b0, pick_capture());
						endcase
					end
					if ($urandom_range(0, 2) == 0) send_item(CH_DASH, 1'b0, pick_capture());
					send_text("-->");
				end
				7: begin
					send_text("<![CDATA[");
					n = $urandom_range(0, 6);
					repeat (n) begin
						case ($urandom_range(0, 3))
							0: send_item(CH_RBRACK, 1'b0, pick_capture());
							1: send_item(CH_GT, 1'b0, pick_capture());
							default: send_item(rand_text_byte(), 1'b0, pick_capture());
						endcase
					end
					send_text("]]>");
				end
				8: begin
					n = $urandom_range(1, 5);
					repeat (n) send_item(8'($urandom), 1'b0, pick_capture());
				end
				default: begin
					send_item(CH_LT, 1'b0, pick_capture());
					send_item(CH_BANG, 1'b0, pick_capture());
					send_item(8'($urandom), 1'b0, pick_capture());
				end
			endcase
		end
		send_eager = 1'b0;
		recv_eager = 1'b0;
	endtask

	task automatic test_end_of_file();
		// steer back to text, leave a "<!" pending, then end the file
		send_text("\"=\"\"/>>");
		send_text("<!");
		send_item(8'($urandom), 1'b1, pick_capture());
		repeat (3) send_item(8'($urandom), 1'($urandom), pick_capture());
	endtask

	// tok ready: random hold-off per transfer, or one long stall on request
	initial begin : drive_tok_ready
		int gap;
		tok_if.ready = 1'b0;
		forever begin
			gap = recv_eager ? 0 : $urandom_range(0, 9);
			if (hold_off_cycles != 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (gap > 0) begin
				@(negedge clk);
				tok_if.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			tok_if.ready <= 1'b1;
			do @(posedge clk); while (!(tok_if.valid && tok_if.ready) && hold_off_cycles == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_if.valid && tok_if.ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("token with nothing pending: tb=%02h code=%0d",
					tok_if.data.text_byte, tok_if.data.event_code));
			end else begin
				tok_want = pending_tokens.pop_front();
				compare_token(tok_if.data, tok_want);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("xml_event_tokenizer_core: mismatch");
		$finish;
	end

	initial begin
		doc_if.valid = 1'b0;
		doc_if.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_tags_and_attributes();
		test_lookahead_and_bang();
		test_comment_and_cdata();
		test_output_stall();
		test_random_documents();
		test_end_of_file();
		@(negedge clk);
		doc_if.valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("xml_event_tokenizer_core: match");
		end else begin
			$display("xml_event_tokenizer_core: mismatch");
		end
		$finish;
	end

endmodule
